/* hdl/pwft_pkg.sv */
// Shared types and constants for the pulse width frame transmitter.
`timescale 1ns / 1ps

package pwft_pkg;

    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FRAME_BITS = 40;
    localparam int unsigned BITNO_W = 6;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [LEVEL_W-1:0] LEVELS_PER_FRAME = 7'd82;
    localparam logic [LEVEL_W-1:0] LAST_TIMED_INDEX = 7'd81;
    localparam logic [TICK_W-1:0]  TICK_MAX = 16'hFFFF;

    localparam logic [BYTE_W-1:0] START_CODE_RST     = 8'd0;
    localparam logic [BYTE_W-1:0] END_CODE_RST       = 8'd0;
    localparam logic [BYTE_W-1:0] LENGTH_CODE_RST    = 8'd1;
    localparam logic [BYTE_W-1:0] REPEAT_COUNT_RST   = 8'd1;
    localparam logic [TICK_W-1:0] PREAMBLE_TICKS_RST = 16'd1000;
    localparam logic [TICK_W-1:0] SHORT_TICKS_RST    = 16'd20;
    localparam logic [TICK_W-1:0] LONG_TICKS_RST     = 16'd40;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_CODE     = 3'd0,
        REG_END_CODE       = 3'd1,
        REG_LENGTH_CODE    = 3'd2,
        REG_REPEAT_COUNT   = 3'd3,
        REG_PREAMBLE_TICKS = 3'd4,
        REG_SHORT_TICKS    = 3'd5,
        REG_LONG_TICKS     = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] status_byte;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
    } out_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] length_code;
        logic [BYTE_W-1:0] repeat_count;
        logic [TICK_W-1:0] preamble_ticks;
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] long_ticks;
    } cfg_regs_t;

endpackage

/* hdl/pwft_half_dur.sv */
// Duration lookup for the level half currently being timed.
`timescale 1ns / 1ps

module pwft_half_dur (
    input  pwft_pkg::cfg_regs_t                   cfg,
    input  logic [pwft_pkg::BYTE_W-1:0]           latched_status,
    input  logic [pwft_pkg::LEVEL_W-1:0]          level_index,
    output logic [pwft_pkg::TICK_W-1:0]           duration
);
    import pwft_pkg::*;

    logic [FRAME_BITS-1:0] frame;
    logic [LEVEL_W-1:0]    bit_offset;
    logic [BITNO_W-1:0]    bitno;
    logic                  bit_one;

    // Frame bits MSB first: bit number 0 sits at the top of the vector.
    assign frame = {cfg.start_code, cfg.length_code, latched_status,
                    cfg.start_code ^ cfg.length_code ^ latched_status,
                    cfg.end_code};

    assign bit_offset = level_index - LEVEL_W'(2);
    assign bitno      = bit_offset[BITNO_W:1];

    always_comb
    begin
        if (bitno < BITNO_W'(FRAME_BITS))
        begin
            bit_one = frame[BITNO_W'(FRAME_BITS - 1) - bitno];
        end
        else
        begin
            bit_one = 1'b0;
        end
    end

    always_comb
    begin
        if (level_index == LEVEL_W'(0))
        begin
            duration = cfg.preamble_ticks;
        end
        else if (level_index == LEVEL_W'(1))
        begin
            duration = cfg.short_ticks;
        end
        else if (!level_index[0])
        begin
            // low half: short for a one
            duration = bit_one ? cfg.short_ticks : cfg.long_ticks;
        end
        else
        begin
            duration = bit_one ? cfg.long_ticks : cfg.short_ticks;
        end
    end

endmodule

/* hdl/pulse_width_frame_transmitter.sv */
// Top level of the pulse width frame transmitter.
`timescale 1ns / 1ps

// Each transaction on the input channel is either a start (latch the status
// byte, arm repeat_count frames) or one time tick; every input transaction
// yields exactly one result carrying the line level and the busy flag after
// that item. One item is accepted per clock cycle and its result appears in
// the output register on the next cycle; the block keeps accepting items
// whenever the output register is empty or being taken in the same cycle, so
// the rate is set only by the output handshake. Registers are written through
// the configuration channel and are read live by the frame timing.
module pulse_width_frame_transmitter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  pwft_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pwft_pkg::out_item_t                  out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pwft_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pwft_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pwft_pkg::*;

    cfg_regs_t           cfg_reg;
    logic [LEVEL_W-1:0]  level_index_reg, level_index_next;
    logic [TICK_W-1:0]   elapsed_ticks_reg, elapsed_ticks_next;
    logic [BYTE_W-1:0]   frames_left_reg, frames_left_next;
    logic [BYTE_W-1:0]   latched_status_reg, latched_status_next;
    logic                line_out_reg, line_out_next;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                in_acc;
    logic                busy_now;
    logic [TICK_W-1:0]   elapsed_inc;
    logic [TICK_W-1:0]   duration;
    logic [LEVEL_W-1:0]  level_adv;
    logic                busy_after;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code     <= START_CODE_RST;
            cfg_reg.end_code       <= END_CODE_RST;
            cfg_reg.length_code    <= LENGTH_CODE_RST;
            cfg_reg.repeat_count   <= REPEAT_COUNT_RST;
            cfg_reg.preamble_ticks <= PREAMBLE_TICKS_RST;
            cfg_reg.short_ticks    <= SHORT_TICKS_RST;
            cfg_reg.long_ticks     <= LONG_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START_CODE:     cfg_reg.start_code     <= cfg_data[BYTE_W-1:0];
                REG_END_CODE:       cfg_reg.end_code       <= cfg_data[BYTE_W-1:0];
                REG_LENGTH_CODE:    cfg_reg.length_code    <= cfg_data[BYTE_W-1:0];
                REG_REPEAT_COUNT:   cfg_reg.repeat_count   <= cfg_data[BYTE_W-1:0];
                REG_PREAMBLE_TICKS: cfg_reg.preamble_ticks <= cfg_data;
                REG_SHORT_TICKS:    cfg_reg.short_ticks    <= cfg_data;
                REG_LONG_TICKS:     cfg_reg.long_ticks     <= cfg_data;
                default:            ;
            endcase
        end
    end

    pwft_half_dur u_half_dur (
        .cfg            (cfg_reg),
        .latched_status (latched_status_reg),
        .level_index    (level_index_reg),
        .duration       (duration)
    );

    assign busy_now    = (frames_left_reg != '0) || (level_index_reg < LAST_TIMED_INDEX);
    assign elapsed_inc = (elapsed_ticks_reg == TICK_MAX) ? elapsed_ticks_reg
                                                         : elapsed_ticks_reg + TICK_W'(1);
    assign level_adv   = level_index_reg + LEVEL_W'(1);

    always_comb
    begin
        level_index_next    = level_index_reg;
        elapsed_ticks_next  = elapsed_ticks_reg;
        frames_left_next    = frames_left_reg;
        latched_status_next = latched_status_reg;
        line_out_next       = line_out_reg;
        if (in_data.command == CMD_START)
        begin
            latched_status_next = in_data.status_byte;
            frames_left_next    = cfg_reg.repeat_count;
        end
        else if (busy_now)
        begin
            elapsed_ticks_next = elapsed_inc;
            if ((level_index_reg < LEVELS_PER_FRAME) && (elapsed_inc >= duration))
            begin
                // even halves end high, odd halves end low
                line_out_next      = !level_index_reg[0];
                elapsed_ticks_next = '0;
                level_index_next   = level_adv;
            end
            if ((frames_left_reg != '0) &&
                ((frames_left_reg == cfg_reg.repeat_count) ||
                 (level_index_next > LAST_TIMED_INDEX)))
            begin
                level_index_next   = '0;
                elapsed_ticks_next = '0;
                line_out_next      = 1'b0;
                frames_left_next   = frames_left_reg - BYTE_W'(1);
            end
        end
        else
        begin
            line_out_next = 1'b1;
        end
    end

    assign busy_after = (frames_left_next != '0) || (level_index_next < LAST_TIMED_INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_index_reg    <= LEVELS_PER_FRAME;
            elapsed_ticks_reg  <= '0;
            frames_left_reg    <= '0;
            latched_status_reg <= '0;
            line_out_reg       <= 1'b1;
        end
        else if (in_acc)
        begin
            level_index_reg    <= level_index_next;
            elapsed_ticks_reg  <= elapsed_ticks_next;
            frames_left_reg    <= frames_left_next;
            latched_status_reg <= latched_status_next;
            line_out_reg       <= line_out_next;
        end
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_data_reg.line_level <= line_out_next;
            out_data_reg.busy_res   <= busy_after;
        end
    end

`ifndef SYNTHESIS
    a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("result register not loaded after accepted transaction");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_index_reg <= LEVELS_PER_FRAME)
        else $error("level index beyond frame");

    a_frames_only_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_data.command == CMD_TICK)) |=>
            (frames_left_reg <= $past(frames_left_reg)))
        else $error("frame count grew on a tick");

    a_elapsed_clears_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(level_index_reg) |-> (elapsed_ticks_reg == '0))
        else $error("elapsed ticks not cleared on level change");
`endif

endmodule

/* tb/pwft_line_checker.sv */
// Line and busy predictor with in-order result comparison for the frame transmitter.
`timescale 1ns / 1ps

module pwft_line_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  pwft_pkg::in_item_t               in_data,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  pwft_pkg::out_item_t              out_data,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [pwft_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pwft_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pending
);

    import pwft_pkg::*;

    cfg_regs_t           regs;
    logic [LEVEL_W-1:0]  half_idx;
    logic [TICK_W-1:0]   half_ticks;
    logic [BYTE_W-1:0]   frames_owed;
    logic [BYTE_W-1:0]   frame_status;
    logic                line_now;

    out_item_t           predicted_line_q[$];
    out_item_t           want;

    function automatic void clear_line_state();
        regs.start_code     = START_CODE_RST;
        regs.end_code       = END_CODE_RST;
        regs.length_code    = LENGTH_CODE_RST;
        regs.repeat_count   = REPEAT_COUNT_RST;
        regs.preamble_ticks = PREAMBLE_TICKS_RST;
        regs.short_ticks    = SHORT_TICKS_RST;
        regs.long_ticks     = LONG_TICKS_RST;
        half_idx     = LEVELS_PER_FRAME;
        half_ticks   = '0;
        frames_owed  = '0;
        frame_status = '0;
        line_now     = 1'b1;
    endfunction

    function automatic void write_shadow(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_START_CODE:     regs.start_code     = val[BYTE_W-1:0];
            REG_END_CODE:       regs.end_code       = val[BYTE_W-1:0];
            REG_LENGTH_CODE:    regs.length_code    = val[BYTE_W-1:0];
            REG_REPEAT_COUNT:   regs.repeat_count   = val[BYTE_W-1:0];
            REG_PREAMBLE_TICKS: regs.preamble_ticks = val;
            REG_SHORT_TICKS:    regs.short_ticks    = val;
            REG_LONG_TICKS:     regs.long_ticks     = val;
            default: ;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] frame_byte(int unsigned pos);
        case (pos)
            0: return regs.start_code;
            1: return regs.length_code;
            2: return frame_status;
            3: return regs.start_code ^ regs.length_code ^ frame_status;
            default: return regs.end_code;
        endcase
    endfunction

    // Duration of the half being timed; bits go out MSB first.
    function automatic logic [TICK_W-1:0] half_len(logic [LEVEL_W-1:0] idx);
        int unsigned       bitno;
        logic [BYTE_W-1:0] fb;
        logic              one;
        if (idx == 0)
            return regs.preamble_ticks;
        if (idx == 1)
            return regs.short_ticks;
        bitno = (int'(idx) - 2) / 2;
        fb  = frame_byte(bitno / 8);
        one = fb[3'(7 - (bitno % 8))];
        if (idx[0] == 1'b0)
            return one ? regs.short_ticks : regs.long_ticks;
        return one ? regs.long_ticks : regs.short_ticks;
    endfunction

    function automatic logic line_busy();
        return (frames_owed != 0) || (half_idx < LAST_TIMED_INDEX);
    endfunction

    function automatic out_item_t next_line_sample(in_item_t item);
        out_item_t r;
        if (item.command == CMD_START) begin
            frame_status = item.status_byte;
            frames_owed  = regs.repeat_count;
        end
        else if (line_busy()) begin
            if (half_ticks != TICK_MAX)
                half_ticks++;
            if (half_idx < LEVELS_PER_FRAME && half_ticks >= half_len(half_idx)) begin
                line_now   = ~half_idx[0];
                half_ticks = '0;
                half_idx++;
            end
            // load a fresh frame when frames_owed equals repeat_count or frame ends
            if (frames_owed != 0 &&
                (frames_owed == regs.repeat_count || half_idx > LAST_TIMED_INDEX)) begin
                half_idx    = '0;
                half_ticks  = '0;
                line_now    = 1'b0;
                frames_owed = frames_owed - 1'b1;
            end
        end
        else begin
            line_now = 1'b1;
        end
        r.line_level = line_now;
        r.busy_res   = line_busy();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line_state();
            predicted_line_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                write_shadow(cfg_index, cfg_data);
            if (in_valid && in_ready)
                predicted_line_q.push_back(next_line_sample(in_data));
            if (out_valid && out_ready)
            begin
                if (predicted_line_q.size() == 0)
                begin
                    $error("out transaction with no prediction: line_level %0b busy_res %0b",
                           out_data.line_level, out_data.busy_res);
                    fail_count++;
                end
                else
                begin
                    want = predicted_line_q.pop_front();
                    if (out_data.line_level !== want.line_level)
                    begin
                        $error("line_level: expected %0b, got %0b",
                               want.line_level, out_data.line_level);
                        fail_count++;
                    end
                    if (out_data.busy_res !== want.busy_res)
                    begin
                        $error("busy_res: expected %0b, got %0b",
                               want.busy_res, out_data.busy_res);
                        fail_count++;
                    end
                end
            end
            pending <= predicted_line_q.size();
        end
    end

endmodule

/* tb/tb_pulse_width_frame_transmitter.sv */
// Stimulus, flow control and verdict for the pulse width frame transmitter.
`timescale 1ns / 1ps

module tb_pulse_width_frame_transmitter;

    import pwft_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned HOLD_CYCLES  = 300;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int                     fail_count;
    int                     pending;
    int unsigned            snd_idle_pct = 27;
    int unsigned            rcv_idle_pct = 57;
    int unsigned            hold_left    = 0;
    int unsigned            items_sent   = 0;
    bit                     hold_toggle  = 1'b0;
    bit                     hold_seen    = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pulse_width_frame_transmitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwft_line_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random stalls, or a long hold-off while hold_left counts down.
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    task automatic push_item(cmd_t cmd, logic [BYTE_W-1:0] status);
        in_item_t item;
        item.command     = cmd;
        item.status_byte = status;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic push_ticks(int unsigned count);
        repeat (count) push_item(CMD_TICK, BYTE_W'($urandom_range(255)));
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic cfg_regs_t random_setup();
        cfg_regs_t c;
        c.start_code   = BYTE_W'($urandom_range(255));
        c.end_code     = BYTE_W'($urandom_range(255));
        c.length_code  = BYTE_W'($urandom_range(255));
        c.repeat_count = BYTE_W'(($urandom_range(4) == 0) ? $urandom_range(4, 255)
                                                          : $urandom_range(1, 3));
        if ($urandom_range(9) == 0)
        begin
            c.preamble_ticks = TICK_W'($urandom_range(1, 2000));
            c.short_ticks    = TICK_W'($urandom_range(1, 40));
            c.long_ticks     = TICK_W'($urandom_range(1, 40));
        end
        else
        begin
            c.preamble_ticks = TICK_W'($urandom_range(1, 10));
            c.short_ticks    = TICK_W'($urandom_range(1, 2));
            c.long_ticks     = TICK_W'($urandom_range(1, 4));
        end
        return c;
    endfunction

    // Rewrite all registers, or a random subset to change them mid-frame.
    task automatic apply_setup(cfg_regs_t c, bit every);
        if (every || $urandom_range(3) != 0)
            write_reg(REG_START_CODE, {8'h00, c.start_code});
        if (every || $urandom_range(3) != 0)
            write_reg(REG_END_CODE, {8'h00, c.end_code});
        if (every || $urandom_range(3) != 0)
            write_reg(REG_LENGTH_CODE, {8'h00, c.length_code});
        if (every || $urandom_range(3) != 0)
            write_reg(REG_REPEAT_COUNT, {8'h00, c.repeat_count});
        if (every || $urandom_range(3) != 0)
            write_reg(REG_PREAMBLE_TICKS, c.preamble_ticks);
        if (every || $urandom_range(3) != 0)
            write_reg(REG_SHORT_TICKS, c.short_ticks);
        if (every || $urandom_range(3) != 0)
            write_reg(REG_LONG_TICKS, c.long_ticks);
    endtask

    initial
    begin
        int unsigned goal;
        int unsigned seg_len;
        int          phase;
        int          phase_now;
        bit          first;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks while idle, status field ignored
        push_item(CMD_TICK, 8'h00);
        push_item(CMD_TICK, 8'hFF);
        // start under reset settings
        push_item(CMD_START, 8'h00);
        push_ticks(3);
        settle();

        // extreme register values, start while a frame is running
        write_reg(REG_START_CODE, 16'h00FF);
        write_reg(REG_END_CODE, 16'h00FF);
        write_reg(REG_LENGTH_CODE, 16'h0000);
        write_reg(REG_REPEAT_COUNT, 16'h00FF);
        write_reg(REG_PREAMBLE_TICKS, 16'hFFFF);
        write_reg(REG_SHORT_TICKS, 16'hFFFF);
        write_reg(REG_LONG_TICKS, 16'hFFFF);
        push_item(CMD_START, 8'hFF);
        push_ticks(3);
        settle();

        // zero repeat count: nothing loaded, current frame keeps running
        write_reg(REG_REPEAT_COUNT, 16'h0000);
        push_item(CMD_START, 8'h5A);
        push_ticks(2);
        settle();

        // zero durations: each tick closes a half
        write_reg(REG_PREAMBLE_TICKS, 16'h0000);
        write_reg(REG_SHORT_TICKS, 16'h0000);
        write_reg(REG_LONG_TICKS, 16'h0000);
        push_ticks(4);
        settle();

        // repeat count rewritten to match frames still owed reloads the frame
        write_reg(REG_REPEAT_COUNT, 16'h0003);
        push_item(CMD_START, 8'hA5);
        push_ticks(1);
        settle();
        write_reg(REG_REPEAT_COUNT, 16'h0002);
        push_ticks(2);
        settle();

        goal  = items_sent + RANDOM_ITEMS;
        phase = -1;
        first = 1'b1;
        while (items_sent < goal)
        begin
            phase_now = int'((RANDOM_ITEMS - (goal - items_sent)) * 3 / RANDOM_ITEMS);
            if (phase_now > 2)
                phase_now = 2;
            apply_setup(random_setup(), first);
            first = 1'b0;
            if (phase_now != phase)
            begin
                phase = phase_now;
                case (phase)
                    0:
                    begin
                        snd_idle_pct  = 27;
                        rcv_idle_pct <= 57;
                    end
                    1:
                    begin
                        snd_idle_pct  = 57;
                        rcv_idle_pct <= 27;
                    end
                    default:
                    begin
                        snd_idle_pct  = 0;
                        rcv_idle_pct <= 0;
                    end
                endcase
                // hold the receiver off while the sender keeps offering
                hold_toggle <= ~hold_toggle;
            end
            seg_len = $urandom_range(80, 320);
            if ($urandom_range(99) < 85)
                push_item(CMD_START, BYTE_W'($urandom_range(255)));
            repeat (seg_len)
            begin
                if ($urandom_range(99) < 3)
                    push_item(CMD_START, BYTE_W'($urandom_range(255)));
                else
                    push_item(CMD_TICK, BYTE_W'($urandom_range(255)));
            end
            settle();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("pulse_width_frame_transmitter: match");
        else
            $display("pulse_width_frame_transmitter: mismatch");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("pulse_width_frame_transmitter: mismatch");
        $finish;
    end

endmodule

/* pulse_width_frame_transmitter.f */
hdl/pwft_pkg.sv
hdl/pwft_half_dur.sv
hdl/pulse_width_frame_transmitter.sv
tb/pwft_line_checker.sv
tb/tb_pulse_width_frame_transmitter.sv
